FILE: sv/gregorian_julian_day_convert_core_defines.svh
// Assertion macros shared by the converter modules.
`ifndef GREGORIAN_JULIAN_DAY_CONVERT_CORE_DEFINES_SVH
`define GREGORIAN_JULIAN_DAY_CONVERT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GJDC_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GJDC_ASSERT_CLK_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GJDC_ASSERT_CLK(label, prop, msg)
`define GJDC_ASSERT_CLK_NORST(label, prop, msg)
`endif
`endif

FILE: sv/gjdc_pkg.sv
`timescale 1ns / 1ps
package gjdc_pkg;

  typedef enum logic {
    OP_DATE_TO_JDN = 1'b0,
    OP_JDN_TO_DATE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     op;
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] day_number;
  } item_t;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [22:0] JDN_FIRST   = 23'd1721426;
  localparam logic [22:0] JDN_LAST    = 23'd5373484;
  localparam logic [13:0] INV25       = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;
  localparam logic [12:0] YEAR_SHIFT  = 13'd4800;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;
  localparam logic [15:0] JDN_OFFSET  = 16'd32045;
  localparam logic [18:0] ERA_BIAS    = 19'd274277;
  localparam logic [17:0] DAYS_ERA    = 18'd146097;
  localparam logic [14:0] RECIP_ERA   = 15'd29398;
  localparam logic [10:0] F_OFFSET    = 11'd1363;
  localparam logic [10:0] DAYS_4Y     = 11'd1461;
  localparam logic [21:0] RECIP_4Y    = 22'd2939744;
  localparam logic [12:0] YEAR_BASE   = 13'd4716;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from the start of the March-based year to the start of shifted month mm.
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] off;
    unique case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: sv/gjdc_front.sv
`timescale 1ns / 1ps
module gjdc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  logic [13:0]      in_year,
  input  logic [3:0]       in_month,
  input  logic [4:0]       in_day,
  input  logic [22:0]      in_day_number,
  input  logic             q_full,
  output logic             q_push,
  output gjdc_pkg::item_t  q_item
);
  import gjdc_pkg::*;

  logic [13:0] y_inv;
  logic        div25;
  logic        leap;
  logic [4:0]  mlen;
  logic        date_ok;
  logic        jdn_ok;
  opcode_t     op;

  // A year is a multiple of 25 exactly when its product with the inverse of 25
  // modulo 2^14 stays at or below the largest multiple count.
  assign y_inv = in_year * INV25;
  assign div25 = (y_inv <= DIV25_LIMIT);
  assign leap  = (in_year[1:0] == 2'd0) && (!div25 || (in_year[3:0] == 4'd0));
  assign mlen  = month_len(in_month, leap);

  assign date_ok = (in_year != 14'd0) && (in_year <= YEAR_MAX)
                && (in_month != 4'd0) && (in_month <= MONTH_MAX)
                && (in_day != 5'd0) && (in_day <= mlen);
  assign jdn_ok  = (in_day_number >= JDN_FIRST) && (in_day_number <= JDN_LAST);
  assign op      = opcode_t'(in_opcode);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op         = op;
    q_item.ok         = (op == OP_JDN_TO_DATE) ? jdn_ok : date_ok;
    q_item.year       = in_year;
    q_item.month      = in_month;
    q_item.day        = in_day;
    q_item.day_number = in_day_number;
  end

endmodule

FILE: sv/gjdc_queue.sv
`timescale 1ns / 1ps
`include "gregorian_julian_day_convert_core_defines.svh"
module gjdc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gjdc_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output gjdc_pkg::item_t  head
);
  import gjdc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `GJDC_ASSERT_CLK(a_count_bound, count_r <= CW'(DEPTH), "Queue count exceeds its depth.")
  `GJDC_ASSERT_CLK(a_no_pop_empty, pop |-> (count_r != '0), "Queue popped while empty.")
  `GJDC_ASSERT_CLK(a_push_grows, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "Queue count did not grow on a lone push.")

endmodule

FILE: sv/gjdc_back.sv
`timescale 1ns / 1ps
`include "gregorian_julian_day_convert_core_defines.svh"
module gjdc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  gjdc_pkg::item_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [22:0]      out_result_day_number,
  output logic [13:0]      out_result_year,
  output logic [3:0]       out_result_month,
  output logic [4:0]       out_result_day,
  output logic             out_valid_res
);
  import gjdc_pkg::*;

  logic adv;

  // Stage 1.
  logic        s1_v_r;
  opcode_t     s1_op_r;
  logic        s1_ok_r;
  logic [4:0]  s1_day_r;
  logic [14:0] s1_yy_r, s1_yy_nxt;
  logic [8:0]  s1_moff_r, s1_moff_nxt;
  logic [22:0] s1_j_r;
  logic [25:0] s1_n1_r, s1_n1_nxt;
  logic        lo_month;
  logic [3:0]  mm0;

  // Stage 2.
  logic        s2_v_r;
  opcode_t     s2_op_r;
  logic        s2_ok_r;
  logic [4:0]  s2_day_r;
  logic [12:0] s2_yyq_r;
  logic [8:0]  s2_moff_r;
  logic [22:0] s2_j_r;
  logic [25:0] s2_n1_r;
  logic [23:0] s2_p365_r, s2_p365_nxt;
  logic [7:0]  s2_q100_r;
  logic [7:0]  s2_t_est_r;
  logic [27:0] qprod;
  logic [39:0] tprod;

  // Stage 3.
  logic        s3_v_r;
  opcode_t     s3_op_r;
  logic        s3_ok_r;
  logic [22:0] s3_j_r;
  logic [23:0] s3_sa_r, s3_sa_nxt;
  logic [15:0] s3_sb_r, s3_sb_nxt;
  logic [7:0]  s3_t_r, s3_t_nxt;
  logic [25:0] tmul;
  logic [25:0] r1;

  // Stage 4.
  logic        s4_v_r;
  opcode_t     s4_op_r;
  logic        s4_ok_r;
  logic [22:0] s4_jdn_r, s4_jdn_nxt;
  logic [25:0] s4_e_r, s4_e_nxt;
  logic [23:0] jdn_full;
  logic [9:0]  c3;
  logic [23:0] f_val;

  // Stage 5.
  logic        s5_v_r;
  opcode_t     s5_op_r;
  logic        s5_ok_r;
  logic [22:0] s5_jdn_r;
  logic [25:0] s5_e_r;
  logic [15:0] s5_qe_r, s5_qe_nxt;
  logic [47:0] eprod;

  // Stage 6.
  logic        s6_v_r;
  opcode_t     s6_op_r;
  logic        s6_ok_r;
  logic [22:0] s6_jdn_r;
  logic [15:0] s6_q_r, s6_q_nxt;
  logic [8:0]  s6_g_r, s6_g_nxt;
  logic [25:0] qm;
  logic [25:0] r2;
  logic        corr;
  logic [11:0] rem;

  // Output stage.
  logic        out_valid_r;
  logic [22:0] out_dn_r, out_dn_nxt;
  logic [13:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic        out_res_r;
  logic [3:0]  mm;
  logic        late;
  logic [8:0]  day_full;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_nonempty;

  // Stage 1: March-based year and month, and the era numerator.
  assign lo_month    = (q_head.month <= 4'd2);
  assign s1_yy_nxt   = {1'b0, q_head.year} + 15'(YEAR_SHIFT) - {14'd0, lo_month};
  assign mm0         = q_head.month + (lo_month ? 4'd12 : 4'd0) - 4'd3;
  assign s1_moff_nxt = month_offset(mm0);
  assign s1_n1_nxt   = 26'({q_head.day_number, 2'b00}) + 26'(ERA_BIAS);

  // Stage 2: constant multiplies, and reciprocal estimates of the quotients.
  assign s2_p365_nxt = 24'(s1_yy_r) * 24'(DAYS_YEAR);
  assign qprod       = 28'(s1_yy_r) * 28'(RECIP_100);
  assign tprod       = 40'(s1_n1_r) * 40'(RECIP_ERA);

  // Stage 3: partial sums, and the era quotient corrected by one compare.
  assign s3_sa_nxt = s2_p365_r + 24'(s2_yyq_r) + 24'(s2_moff_r) + 24'(s2_day_r);
  assign s3_sb_nxt = 16'(s2_q100_r) - 16'(s2_q100_r[7:2]) + JDN_OFFSET;
  assign tmul      = 26'(s2_t_est_r) * 26'(DAYS_ERA);
  assign r1        = s2_n1_r - tmul;
  assign s3_t_nxt  = s2_t_est_r + {7'd0, (r1 >= 26'(DAYS_ERA))};

  // Stage 4: final day number, and the day count shifted into four-year units.
  assign jdn_full   = s3_sa_r - 24'(s3_sb_r);
  assign s4_jdn_nxt = jdn_full[22:0];
  assign c3         = 10'(s3_t_r) * 10'd3;
  assign f_val      = 24'(s3_j_r) + 24'(F_OFFSET) + 24'(c3[9:2]);
  assign s4_e_nxt   = {f_val, 2'b11};

  // Stage 5: reciprocal estimate of the four-year quotient.
  assign eprod     = 48'(s4_e_r) * 48'(RECIP_4Y);
  assign s5_qe_nxt = eprod[47:32];

  // Stage 6: correct the quotient and take the day of the shifted year.
  assign qm       = 26'(s5_qe_r) * 26'(DAYS_4Y);
  assign r2       = s5_e_r - qm;
  assign corr     = (r2[11:0] >= 12'(DAYS_4Y));
  assign s6_q_nxt = s5_qe_r + {15'd0, corr};
  assign rem      = corr ? (r2[11:0] - 12'(DAYS_4Y)) : r2[11:0];
  assign s6_g_nxt = rem[10:2];

  // Output stage: the shifted month is the count of month starts not after the day.
  always_comb begin
    mm = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mm = mm + {3'd0, (s6_g_r >= month_offset(4'(k)))};
    end
  end

  assign late     = (mm >= 4'd10);
  assign day_full = s6_g_r - month_offset(mm) + 9'd1;

  always_comb begin
    out_dn_nxt    = '0;
    out_year_nxt  = '0;
    out_month_nxt = '0;
    out_day_nxt   = '0;
    if (s6_ok_r) begin
      if (s6_op_r == OP_JDN_TO_DATE) begin
        out_year_nxt  = s6_q_r[13:0] - 14'(YEAR_BASE) + {13'd0, late};
        out_month_nxt = late ? (mm - 4'd9) : (mm + 4'd3);
        out_day_nxt   = day_full[4:0];
      end else begin
        out_dn_nxt = s6_jdn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      out_valid_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= q_head.op;
      s1_ok_r    <= q_head.ok;
      s1_day_r   <= q_head.day;
      s1_yy_r    <= s1_yy_nxt;
      s1_moff_r  <= s1_moff_nxt;
      s1_j_r     <= q_head.day_number;
      s1_n1_r    <= s1_n1_nxt;

      s2_op_r    <= s1_op_r;
      s2_ok_r    <= s1_ok_r;
      s2_day_r   <= s1_day_r;
      s2_yyq_r   <= s1_yy_r[14:2];
      s2_moff_r  <= s1_moff_r;
      s2_j_r     <= s1_j_r;
      s2_n1_r    <= s1_n1_r;
      s2_p365_r  <= s2_p365_nxt;
      s2_q100_r  <= qprod[26:19];
      s2_t_est_r <= tprod[39:32];

      s3_op_r    <= s2_op_r;
      s3_ok_r    <= s2_ok_r;
      s3_j_r     <= s2_j_r;
      s3_sa_r    <= s3_sa_nxt;
      s3_sb_r    <= s3_sb_nxt;
      s3_t_r     <= s3_t_nxt;

      s4_op_r    <= s3_op_r;
      s4_ok_r    <= s3_ok_r;
      s4_jdn_r   <= s4_jdn_nxt;
      s4_e_r     <= s4_e_nxt;

      s5_op_r    <= s4_op_r;
      s5_ok_r    <= s4_ok_r;
      s5_jdn_r   <= s4_jdn_r;
      s5_e_r     <= s4_e_r;
      s5_qe_r    <= s5_qe_nxt;

      s6_op_r    <= s5_op_r;
      s6_ok_r    <= s5_ok_r;
      s6_jdn_r   <= s5_jdn_r;
      s6_q_r     <= s6_q_nxt;
      s6_g_r     <= s6_g_nxt;

      out_dn_r    <= out_dn_nxt;
      out_year_r  <= out_year_nxt;
      out_month_r <= out_month_nxt;
      out_day_r   <= out_day_nxt;
      out_res_r   <= s6_ok_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_day_number = out_dn_r;
  assign out_result_year       = out_year_r;
  assign out_result_month      = out_month_r;
  assign out_result_day        = out_day_r;
  assign out_valid_res         = out_res_r;

  `GJDC_ASSERT_CLK(a_pop_loads, q_pop |=> s1_v_r, "A popped item did not enter the first stage.")
  `GJDC_ASSERT_CLK(a_stall_freezes, (out_valid_r && out_stall) |=> (s1_v_r == $past(s1_v_r)), "The pipeline moved while the output was stalled.")
  `GJDC_ASSERT_CLK(a_invalid_zero, (out_valid_r && !out_res_r) |-> ((out_dn_r == '0) && (out_year_r == '0) && (out_month_r == '0) && (out_day_r == '0)), "An invalid result carries nonzero fields.")
  `GJDC_ASSERT_CLK(a_date_sane, (out_valid_r && (out_month_r != '0)) |-> ((out_month_r <= MONTH_MAX) && (out_day_r != '0) && (out_dn_r == '0)), "A date result is malformed.")
  `GJDC_ASSERT_CLK_NORST(a_reset_clears, !rst_n |=> !out_valid_r, "Reset did not clear the output stage.")

endmodule

FILE: sv/gregorian_julian_day_convert_core.sv
`timescale 1ns / 1ps
// A transfer into an empty queue is written there, then passes the seven-stage
// conversion pipeline. Throughput: one transfer per cycle while the output is not
// stalled (reciprocal multiplies; era and 4-year quotients get a one-step fix).
// The input queue holds QUEUE_DEPTH items while the output is stalled.
// Reset is synchronous and active low; it empties the queue and the pipeline at once.
module gregorian_julian_day_convert_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [22:0] in_day_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [22:0] out_result_day_number,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic        out_valid_res
);
  import gjdc_pkg::*;

  item_t push_item;
  item_t head;
  logic  push;
  logic  full;
  logic  pop;
  logic  nonempty;

  gjdc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_day_number (in_day_number),
    .q_full        (full),
    .q_push        (push),
    .q_item        (push_item)
  );

  gjdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  gjdc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_nonempty            (nonempty),
    .q_head                (head),
    .q_pop                 (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_day_number (out_result_day_number),
    .out_result_year       (out_result_year),
    .out_result_month      (out_result_month),
    .out_result_day        (out_result_day),
    .out_valid_res         (out_valid_res)
  );

endmodule
